[src/nearest_neighbour_image_resize_core_defines.svh]
// assertion macros used by the checker file of the frame scaler
`ifndef NEAREST_NEIGHBOUR_IMAGE_RESIZE_CORE_DEFINES_SVH
`define NEAREST_NEIGHBOUR_IMAGE_RESIZE_CORE_DEFINES_SVH

// consequent checked at the same edge as the antecedent
`define NNR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked at the edge after the antecedent
`define NNR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/nnr_pkg.sv]
// shared types and constants of the nearest neighbor frame scaler
`default_nettype none

package nnr_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd3;

    // item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] pixel_in;
    } nnr_item_t;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic [7:0]  dst_row;
        logic [7:0]  dst_col;
        logic        last_of_frame;
    } nnr_result_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic cfg_wr;
        logic load_wr;
        logic setup;
        logic prep;
        logic step;
        logic sel_col;
        logic addr_mul;
        logic addr_add;
        logic rd;
        logic out_load;
    } nnr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_emit;
        logic div_last;
        logic out_free;
    } nnr_stat_t;

endpackage

`default_nettype wire

[src/nnr_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none

module nnr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/nnr_ctrl.sv]
// sequencing state machine of the frame scaler
`default_nettype none

module nnr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    output nnr_pkg::nnr_cmd_t cmd,
    input  nnr_pkg::nnr_stat_t stat
);

    import nnr_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LOAD = 9'b000000010,
        S_SETUP = 9'b000000100,
        S_PREP = 9'b000001000,
        S_DIV = 9'b000010000,
        S_AMUL = 9'b000100000,
        S_AADD = 9'b001000000,
        S_READ = 9'b010000000,
        S_OUT = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   col_sel_reg;
    logic   col_sel_next;

    always_comb
    begin
        state_next   = state_reg;
        col_sel_next = col_sel_reg;
        cmd          = '0;
        item_ready   = 1'b0;
        cfg_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                // configuration wins over an item in the same cycle
                cfg_ready  = 1'b1;
                item_ready = !cfg_valid;
                cmd.cfg_wr = cfg_valid;
                if (item_valid && !cfg_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = stat.op_emit ? S_SETUP : S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_SETUP:
            begin
                cmd.setup    = 1'b1;
                col_sel_next = 1'b0;
                state_next   = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep    = 1'b1;
                cmd.sel_col = col_sel_reg;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.step    = 1'b1;
                cmd.sel_col = col_sel_reg;
                if (stat.div_last)
                begin
                    if (col_sel_reg)
                    begin
                        state_next = S_AMUL;
                    end
                    else
                    begin
                        col_sel_next = 1'b1;
                        state_next   = S_PREP;
                    end
                end
            end
            S_AMUL:
            begin
                cmd.addr_mul = 1'b1;
                state_next   = S_AADD;
            end
            S_AADD:
            begin
                cmd.addr_add = 1'b1;
                state_next   = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            col_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_sel_reg <= col_sel_next;
        end
    end

endmodule

`default_nettype wire

[src/nnr_datapath.sv]
// registers, index divider, address math and frame store of the scaler
`default_nettype none

module nnr_datapath #(
    parameter int MAX_SIDE   = 256,
    parameter int PIXEL_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nnr_pkg::nnr_cmd_t                 cmd,
    output nnr_pkg::nnr_stat_t                stat,
    input  nnr_pkg::nnr_item_t                item,
    input  logic [nnr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nnr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              result_ready,
    output logic                              result_valid,
    output nnr_pkg::nnr_result_t              result
);

    import nnr_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TOT_W  = $clog2(DEPTH + 1);
    localparam int NUM_W  = 2 * IDX_W + 2;
    localparam int DEN_W  = IDX_W + 1;
    localparam int STEP_W = $clog2(IDX_W + 1);

    // zero reads as one, anything above the largest side saturates
    function automatic logic [SIDE_W-1:0] side_of(input logic [CFG_DATA_W-1:0] v);
        logic [SIDE_W-1:0] s;
        if (v == '0)
        begin
            s = SIDE_W'(1);
        end
        else if (int'(v) > MAX_SIDE)
        begin
            s = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            s = SIDE_W'(v);
        end
        return s;
    endfunction

    // control state
    logic [CFG_DATA_W-1:0] src_height_reg, src_height_next;
    logic [CFG_DATA_W-1:0] src_width_reg, src_width_next;
    logic [CFG_DATA_W-1:0] dst_height_reg, dst_height_next;
    logic [CFG_DATA_W-1:0] dst_width_reg, dst_width_next;
    logic [ADDR_W-1:0]     load_pos_reg, load_pos_next;
    logic [IDX_W-1:0]      out_row_reg, out_row_next;
    logic [IDX_W-1:0]      out_col_reg, out_col_next;
    logic                  result_valid_reg, result_valid_next;

    // payload
    logic [TOT_W-1:0]      total_reg;
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [IDX_W-1:0]      r_reg;
    logic [IDX_W-1:0]      c_reg;
    logic [IDX_W-1:0]      sr_reg;
    logic [IDX_W-1:0]      sc_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [NUM_W-1:0]      dsh_reg;
    logic [IDX_W-1:0]      q_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [ADDR_W-1:0]     prod_reg;
    logic [ADDR_W-1:0]     addr_reg;
    nnr_result_t           result_reg;

    logic [SIDE_W-1:0]         sh, sw, dh, dw;
    logic [2*SIDE_W-1:0]       total_full;
    logic [ADDR_W-1:0]         load_addr;
    logic [TOT_W-1:0]          load_inc;
    logic                      wrap;
    logic [IDX_W-1:0]          op_d;
    logic [SIDE_W-1:0]         op_s;
    logic [SIDE_W-1:0]         op_n;
    logic [IDX_W-1:0]          s_m1;
    logic [IDX_W-1:0]          n_m1;
    logic [2*IDX_W-1:0]        mul_prod;
    logic [NUM_W-1:0]          num;
    logic [DEN_W-1:0]          den;
    logic                      ge;
    logic [IDX_W-1:0]          q_next;
    logic [IDX_W+SIDE_W-1:0]   amul;
    logic [TOT_W-1:0]          asum;
    logic [SIDE_W-1:0]         col_inc;
    logic [SIDE_W-1:0]         row_inc;
    logic                      is_last;
    logic [PIXEL_BITS-1:0]     ram_rdata;

    assign sh = side_of(src_height_reg);
    assign sw = side_of(src_width_reg);
    assign dh = side_of(dst_height_reg);
    assign dw = side_of(dst_width_reg);

    assign total_full = {{SIDE_W{1'b0}}, sh} * {{SIDE_W{1'b0}}, sw};

    // configuration writes
    always_comb
    begin
        src_height_next = src_height_reg;
        src_width_next  = src_width_reg;
        dst_height_next = dst_height_reg;
        dst_width_next  = dst_width_reg;
        if (cmd.cfg_wr)
        begin
            case (cfg_index)
                REG_SRC_HEIGHT: src_height_next = cfg_data;
                REG_SRC_WIDTH:  src_width_next  = cfg_data;
                REG_DST_HEIGHT: dst_height_next = cfg_data;
                REG_DST_WIDTH:  dst_width_next  = cfg_data;
                default:        ;
            endcase
        end
    end

    // raster load position, restarted when beyond the frame
    always_comb
    begin
        load_addr     = (TOT_W'(load_pos_reg) >= total_reg) ? '0 : load_pos_reg;
        load_inc      = TOT_W'(load_addr) + TOT_W'(1);
        load_pos_next = load_pos_reg;
        if (cmd.load_wr)
        begin
            load_pos_next = (load_inc >= total_reg) ? '0 : ADDR_W'(load_inc);
        end
    end

    assign wrap = (SIDE_W'(out_row_reg) >= dh) || (SIDE_W'(out_col_reg) >= dw);

    // divider operands: 2*d*(s-1) + (n-1) over 2*(n-1)
    always_comb
    begin
        op_d     = cmd.sel_col ? c_reg : r_reg;
        op_s     = cmd.sel_col ? sw : sh;
        op_n     = cmd.sel_col ? dw : dh;
        s_m1     = IDX_W'(op_s - SIDE_W'(1));
        n_m1     = IDX_W'(op_n - SIDE_W'(1));
        mul_prod = {{IDX_W{1'b0}}, op_d} * {{IDX_W{1'b0}}, s_m1};
        num      = (NUM_W'(mul_prod) << 1) + NUM_W'(n_m1);
        // a single row or column always maps to zero, any nonzero divisor will do
        den      = (n_m1 == '0) ? DEN_W'(2) : {n_m1, 1'b0};
    end

    // one restoring step per cycle
    assign ge     = rem_reg >= dsh_reg;
    assign q_next = IDX_W'({q_reg, ge});

    assign amul = {{SIDE_W{1'b0}}, sr_reg} * {{IDX_W{1'b0}}, sw};
    assign asum = TOT_W'(prod_reg) + TOT_W'(sc_reg);

    // destination raster advance
    always_comb
    begin
        col_inc           = SIDE_W'(c_reg) + SIDE_W'(1);
        row_inc           = SIDE_W'(r_reg) + SIDE_W'(1);
        is_last           = (SIDE_W'(r_reg) == dh - SIDE_W'(1)) &&
                            (SIDE_W'(c_reg) == dw - SIDE_W'(1));
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
            if (col_inc >= dw)
            begin
                out_col_next = '0;
                out_row_next = (row_inc >= dh) ? '0 : IDX_W'(row_inc);
            end
            else
            begin
                out_col_next = IDX_W'(col_inc);
                out_row_next = r_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_height_reg   <= CFG_DATA_W'(1);
            src_width_reg    <= CFG_DATA_W'(1);
            dst_height_reg   <= CFG_DATA_W'(1);
            dst_width_reg    <= CFG_DATA_W'(1);
            load_pos_reg     <= '0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            src_height_reg   <= src_height_next;
            src_width_reg    <= src_width_next;
            dst_height_reg   <= dst_height_next;
            dst_width_reg    <= dst_width_next;
            load_pos_reg     <= load_pos_next;
            out_row_reg      <= out_row_next;
            out_col_reg      <= out_col_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= TOT_W'(total_full);
        if (cmd.capture)
        begin
            pix_reg <= PIXEL_BITS'(item.pixel_in);
        end
        if (cmd.setup)
        begin
            r_reg <= wrap ? '0 : out_row_reg;
            c_reg <= wrap ? '0 : out_col_reg;
        end
        if (cmd.prep)
        begin
            rem_reg  <= num;
            dsh_reg  <= NUM_W'(den) << (IDX_W - 1);
            q_reg    <= '0;
            step_reg <= STEP_W'(IDX_W - 1);
        end
        if (cmd.step)
        begin
            rem_reg  <= ge ? rem_reg - dsh_reg : rem_reg;
            dsh_reg  <= dsh_reg >> 1;
            q_reg    <= q_next;
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                if (cmd.sel_col)
                begin
                    sc_reg <= q_next;
                end
                else
                begin
                    sr_reg <= q_next;
                end
            end
        end
        if (cmd.addr_mul)
        begin
            prod_reg <= ADDR_W'(amul);
        end
        if (cmd.addr_add)
        begin
            addr_reg <= (asum >= total_reg) ? '0 : ADDR_W'(asum);
        end
        if (cmd.out_load)
        begin
            result_reg.pixel_out     <= 16'(ram_rdata);
            result_reg.dst_row       <= 8'(r_reg);
            result_reg.dst_col       <= 8'(c_reg);
            result_reg.last_of_frame <= is_last;
        end
    end

    nnr_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (cmd.load_wr),
        .wr_addr (load_addr),
        .wr_data (pix_reg),
        .rd_en   (cmd.rd),
        .rd_addr (addr_reg),
        .rd_data (ram_rdata)
    );

    assign stat.op_emit  = (item.opcode == OP_EMIT);
    assign stat.div_last = (step_reg == '0);
    assign stat.out_free = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

[src/nearest_neighbour_image_resize_core.sv]
// top level of the nearest neighbor grayscale frame scaler
`default_nettype none

// Nearest neighbor grayscale frame scaler. A load item (opcode 0) writes its
// pixel at the next raster position of the source frame, wrapping after
// src_height*src_width loads; an emit item (opcode 1) returns the next pixel
// of the destination frame in raster order together with its row, column and
// an end of frame flag. Destination index i maps to source index
// round_half_up(i*(src-1)/(dst-1)), exact in integers, and a destination side
// of one maps everything to index zero. Size registers of zero read as one and
// sizes above MAX_SIDE saturate. Items are handled one at a time: a load
// writes the frame store before the next ready, and an emit also waits
// while the previous result still waits downstream. The emit time is set by
// the shared restoring divider, which retires one quotient bit per cycle and
// runs once for the row index and once for the column index, followed by one
// multiply for the row offset, an add and a registered read of the frame store.
// The frame store is not cleared; emit only after a full source frame has
// been loaded. Configuration writes are taken whenever no item is in flight.

module nearest_neighbour_image_resize_core #(
    parameter int MAX_SIDE   = 256,
    parameter int PIXEL_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // item channel
    input  logic                           item_valid,
    output logic                           item_ready,
    input  nnr_pkg::nnr_item_t             item,
    // result channel
    output logic                           result_valid,
    input  logic                           result_ready,
    output nnr_pkg::nnr_result_t           result,
    // configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nnr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnr_pkg::CFG_DATA_W-1:0] cfg_data
);

    import nnr_pkg::*;

    nnr_cmd_t  cmd;
    nnr_stat_t stat;

    // state machine: handshakes and step sequencing
    nnr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // datapath: size registers, positions, divider, frame store, result register
    nnr_datapath #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

[src/nnr_checker.sv]
// port level checks of the frame scaler and their bind
`default_nettype none
`include "nearest_neighbour_image_resize_core_defines.svh"

module nnr_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic                 result_valid,
    input logic                 result_ready,
    input nnr_pkg::nnr_result_t result
);

    import nnr_pkg::*;

    // a stalled result item holds
    `NNR_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result), "result item dropped or changed while stalled")

    // items are taken one at a time
    `NNR_ASSERT_NEXT(a_one_item, clk, rst_n, item_valid && item_ready, !item_ready, "item taken while another is in flight")

    // configuration and items never complete together
    `NNR_ASSERT_SAME(a_cfg_excl, clk, rst_n, cfg_valid && cfg_ready, !(item_valid && item_ready), "configuration write and item taken in one cycle")

    // a new result comes out of a busy emit
    `NNR_ASSERT_SAME(a_result_busy, clk, rst_n, $rose(result_valid), $past(!item_ready), "result appeared while the block was idle")

endmodule

bind nearest_neighbour_image_resize_core nnr_checker u_nnr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

[tb/tb_nearest_neighbour_image_resize_core.sv]
`timescale 1ns / 1ps
// testbench of the nearest neighbor frame scaler: directed and random items checked against a predictor

module tb_nearest_neighbour_image_resize_core;
    import nnr_pkg::*;

    localparam int MAX_SIDE      = 256;
    localparam int STALL_LIMIT   = 4000;   // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 40;     // well past the longest item latency
    localparam int LONG_HOLD     = 450;    // receiver hold-off in the backpressure test
    localparam int RANDOM_ITEMS  = 240;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    nnr_item_t             item;
    logic                  result_valid;
    logic                  result_ready;
    nnr_result_t           result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nearest_neighbour_image_resize_core #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (16)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // shadow of the scaler state, kept by the predictor
    logic [15:0]           src_pixels [0:MAX_SIDE*MAX_SIDE-1];
    logic [CFG_DATA_W-1:0] size_reg [0:3];
    int unsigned           load_pos;
    int unsigned           out_r;
    int unsigned           out_c;
    // store positions [0, loaded_words) hold written pixels
    int unsigned           loaded_words;
    // pixels still owed by the scaler, oldest first
    nnr_result_t           expected_pixels [$];

    int unsigned error_count;
    int unsigned idle_cycles;
    int unsigned burst_left;
    bit          long_hold_req;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // size register as the scaler sees it: zero reads as one, big values saturate
    function automatic int unsigned eff_side(input logic [CFG_DATA_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_SIDE)
            return MAX_SIDE;
        return raw;
    endfunction

    // nearest source index of destination index d, rounded half up in integers
    function automatic int unsigned nearest_src(input int unsigned d, input int unsigned s,
                                                input int unsigned n);
        int unsigned num;
        int unsigned den;
        if (n <= 1)
            return 0;
        num = 2 * d * (s - 1) + (n - 1);
        den = 2 * (n - 1);
        return num / den;
    endfunction

    function automatic int unsigned src_words();
        return eff_side(size_reg[REG_SRC_HEIGHT]) * eff_side(size_reg[REG_SRC_WIDTH]);
    endfunction

    // advance the shadow state by one accepted item, queue the pixel an emit owes
    function automatic void track_item(input nnr_item_t it);
        int unsigned sh;
        int unsigned sw;
        int unsigned dh;
        int unsigned dw;
        int unsigned total;
        int unsigned addr;
        nnr_result_t px;
        sh    = eff_side(size_reg[REG_SRC_HEIGHT]);
        sw    = eff_side(size_reg[REG_SRC_WIDTH]);
        dh    = eff_side(size_reg[REG_DST_HEIGHT]);
        dw    = eff_side(size_reg[REG_DST_WIDTH]);
        total = sh * sw;
        if (it.opcode == OP_LOAD)
        begin
            // a shrunk frame restarts the raster position
            if (load_pos >= total)
                load_pos = 0;
            src_pixels[load_pos] = it.pixel_in;
            load_pos++;
            if (load_pos >= total)
                load_pos = 0;
        end
        else
        begin
            // a shrunk destination restarts the output raster
            if (out_r >= dh || out_c >= dw)
            begin
                out_r = 0;
                out_c = 0;
            end
            addr = nearest_src(out_r, sh, dh) * sw + nearest_src(out_c, sw, dw);
            if (addr >= total)
                addr = 0;
            px.pixel_out     = src_pixels[addr];
            px.dst_row       = 8'(out_r);
            px.dst_col       = 8'(out_c);
            px.last_of_frame = (out_r == dh - 1) && (out_c == dw - 1);
            expected_pixels.insert(expected_pixels.size(), px);
            out_c++;
            if (out_c >= dw)
            begin
                out_c = 0;
                out_r++;
                if (out_r >= dh)
                    out_r = 0;
            end
        end
    endfunction

    // offer one item; the sender works in bursts with random gaps between them
    task automatic push_item(input logic op, input logic [15:0] pix);
        int unsigned gap;
        nnr_item_t   nxt;
        nxt.opcode   = op;
        nxt.pixel_in = pix;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item       <= nxt;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        track_item(item);
    endtask

    // drop valid and wait until the scaler is idle with nothing owed
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // valid stays high across back to back writes, the caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        size_reg[idx] = val;
    endtask

    task automatic reconfigure(input logic [CFG_DATA_W-1:0] sh, input logic [CFG_DATA_W-1:0] sw,
                               input logic [CFG_DATA_W-1:0] dh, input logic [CFG_DATA_W-1:0] dw);
        settle();
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_DST_WIDTH, dw);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // destination sizes only, the loaded source frame stays usable
    task automatic resize_output(input logic [CFG_DATA_W-1:0] dh,
                                 input logic [CFG_DATA_W-1:0] dw);
        settle();
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_DST_WIDTH, dw);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one full source frame of random pixels, covers every store position in use
    task automatic load_frame();
        int unsigned total;
        total = src_words();
        for (int unsigned i = 0; i < total; i++)
            push_item(OP_LOAD, 16'($urandom_range(0, 65535)));
        if (total > loaded_words)
            loaded_words = total;
    endtask

    task automatic emit_pixels(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            push_item(OP_EMIT, 16'($urandom_range(0, 65535)));
    endtask

    // reset sizes are all one: every emit returns the last loaded pixel
    task automatic test_single_pixel();
        push_item(OP_LOAD, 16'h0000);
        push_item(OP_EMIT, 16'hffff);
        push_item(OP_LOAD, 16'hffff);
        push_item(OP_EMIT, 16'h0000);
        push_item(OP_LOAD, 16'h5a5a);
        push_item(OP_EMIT, 16'ha5a5);
        push_item(OP_EMIT, 16'h1234);
        loaded_words = 1;
    endtask

    // 2x2 up to 3x3: the middle index sits exactly on one half and must round up,
    // one extra emit wraps into the next destination frame
    task automatic test_half_up_rounding();
        reconfigure(9'd2, 9'd2, 9'd3, 9'd3);
        push_item(OP_LOAD, 16'h0000);
        push_item(OP_LOAD, 16'hffff);
        push_item(OP_LOAD, 16'h5555);
        push_item(OP_LOAD, 16'haaaa);
        if (loaded_words < 4)
            loaded_words = 4;
        emit_pixels(10);
    endtask

    // zero and oversized registers: a 1x256 source scaled to one row of 256 columns
    task automatic test_extreme_sizes();
        reconfigure(9'd0, 9'd511, 9'd1, 9'd257);
        load_frame();
        emit_pixels(256);
    endtask

    // receiver holds off for a long stretch while emits keep coming, so the
    // scaler backs up into its item channel
    task automatic test_output_backpressure();
        reconfigure(9'd3, 9'd3, 9'd4, 9'd4);
        load_frame();
        long_hold_req = 1'b1;
        burst_left    = 40;
        emit_pixels(40);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_src_side();
        if ($urandom_range(0, 7) == 0)
            return '0;
        return CFG_DATA_W'($urandom_range(1, 8));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dst_side();
        if ($urandom_range(0, 9) == 0)
            return CFG_DATA_W'($urandom_range(9, 511));
        return CFG_DATA_W'($urandom_range(0, 9));
    endfunction

    // random sizes, frames reloaded when the store does not yet cover them or at random,
    // then a mix of mostly emits and some loads; size changes land mid-frame
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned mix;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                resize_output(pick_dst_side(), pick_dst_side());
            else
            begin
                reconfigure(pick_src_side(), pick_src_side(), pick_dst_side(), pick_dst_side());
                if (src_words() > loaded_words || $urandom_range(0, 1) == 0)
                begin
                    sent += src_words();
                    load_frame();
                end
            end
            mix = $urandom_range(8, 60);
            for (int unsigned i = 0; i < mix; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_item(OP_LOAD, 16'($urandom_range(0, 65535)));
                else
                    push_item(OP_EMIT, 16'($urandom_range(0, 65535)));
            end
            sent += mix;
        end
    endtask

    // receiver: modes of always ready, random stalls and a fixed duty pattern,
    // plus the long hold on request
    initial
    begin : rx_pattern
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        result_ready = 1'b0;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        tick         = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= ($urandom_range(0, 3) != 0);
                    default: result_ready <= ((tick % 7) < 4);
                endcase
            end
        end
    end

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("time %0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    // every accepted pixel against the oldest one owed
    always @(posedge clk)
    begin : pixel_check
        nnr_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                error_count++;
                $display("time %0t: unexpected pixel, expected none, got 0x%0h",
                         $time, result);
            end
            else
            begin
                want = expected_pixels.pop_front();
                compare_field("pixel_out", want.pixel_out, result.pixel_out);
                compare_field("dst_row", want.dst_row, result.dst_row);
                compare_field("dst_col", want.dst_col, result.dst_col);
                compare_field("last_of_frame", want.last_of_frame, result.last_of_frame);
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("time %0t: no handshake for %0d cycles, %0d pixels still owed",
                     $time, STALL_LIMIT, expected_pixels.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        long_hold_req = 1'b0;
        burst_left    = 0;
        error_count   = 0;
        idle_cycles   = 0;
        load_pos      = 0;
        out_r         = 0;
        out_c         = 0;
        loaded_words  = 0;
        for (int i = 0; i < 4; i++)
            size_reg[i] = 9'd1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_pixel();
        test_half_up_rounding();
        test_extreme_sizes();
        test_output_backpressure();
        test_random_frames();

        // drain, then a quiet stretch so stray pixels still get caught
        settle();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
